// ===== design/tli_pkg.sv =====
package tli_pkg;

  // default table size
  localparam int TABLE_DEPTH_DEF = 64;

  // payload widths
  localparam int KEY_W    = 16;
  localparam int COEF_W   = 16;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;
  localparam int POINTS_W = 7;

  // divider widths: |(x-a)*(fc-fa)| < 2^33, c-a < 2^16
  localparam int NUM_W = 33;
  localparam int DEN_W = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SPAN  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ORDER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic scan_first;
    logic scan_next;
    logic take_exact;
    logic mul;
    logic div_start;
    logic take_quot;
    logic commit;
  } tli_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_scan;
    logic key_eq;
    logic key_gt;
    logic div_busy;
    logic out_free;
  } tli_stat_t;

endpackage

// ===== design/tli_if.sv =====
// request channel
interface tli_req_if;
  logic                                valid;
  logic                                ready;
  logic        [tli_pkg::REQ_W-1:0]    req_type;
  logic signed [tli_pkg::KEY_W-1:0]    angle;
  logic signed [tli_pkg::COEF_W-1:0]   coefficient;

  modport source (output valid, req_type, angle, coefficient, input ready);
  modport sink   (input valid, req_type, angle, coefficient, output ready);
endinterface

// response channel
interface tli_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [tli_pkg::COEF_W-1:0]   result_coef;
  logic        [tli_pkg::STATUS_W-1:0] status;
  logic        [tli_pkg::POINTS_W-1:0] points_stored;

  modport source (output valid, result_coef, status, points_stored, input ready);
  modport sink   (input valid, result_coef, status, points_stored, output ready);
endinterface

// ===== design/tli_div.sv =====
module tli_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tli_pkg::NUM_W-1:0]  dividend,
  input  logic [tli_pkg::DEN_W-1:0]  divisor,
  output logic                       busy,
  output logic [tli_pkg::NUM_W-1:0]  quotient
);

  localparam int NW = tli_pkg::NUM_W;
  localparam int DW = tli_pkg::DEN_W;
  localparam int SW = $clog2(NW + 1);

  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [SW-1:0] steps;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // one restoring step per cycle
  assign shifted = {rem, quo[NW-1]};
  assign diff    = shifted - {1'b0, den};
  assign ge      = shifted >= {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= SW'(NW);
    end else if (busy) begin
      steps <= steps - 1'b1;
      busy  <= (steps != SW'(1));
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[NW-2:0], ge};
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign quotient = quo;

endmodule

// ===== design/tli_ctrl.sv =====
module tli_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tli_pkg::tli_stat_t stat,
  output tli_pkg::tli_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_EVAL     = 8'b0000_0010,
    S_SCAN_RD  = 8'b0000_0100,
    S_SCAN_CHK = 8'b0000_1000,
    S_MUL      = 8'b0001_0000,
    S_DIV_GO   = 8'b0010_0000,
    S_DIV_WAIT = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.need_scan) begin
          cmd.scan_first = 1'b1;
          state_next     = S_SCAN_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        priority if (stat.key_eq) begin
          cmd.take_exact = 1'b1;
          state_next     = S_FINISH;
        end else if (stat.key_gt) begin
          state_next = S_MUL;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!stat.div_busy) begin
          cmd.take_quot = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/tli_dp.sv =====
module tli_dp #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tli_pkg::tli_cmd_t                   cmd,
  output tli_pkg::tli_stat_t                  stat,
  input  logic        [tli_pkg::REQ_W-1:0]    in_req_type,
  input  logic signed [tli_pkg::KEY_W-1:0]    in_angle,
  input  logic signed [tli_pkg::COEF_W-1:0]   in_coefficient,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tli_pkg::COEF_W-1:0]   out_coef,
  output logic        [tli_pkg::STATUS_W-1:0] out_status,
  output logic        [tli_pkg::POINTS_W-1:0] out_points
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = tli_pkg::KEY_W;
  localparam int VW = tli_pkg::COEF_W;

  // latched request
  logic        [tli_pkg::REQ_W-1:0] req_q;
  logic signed [KW-1:0]             x_q;
  logic signed [VW-1:0]             v_q;

  // table state
  logic signed [KW-1:0] key_mem [TABLE_DEPTH];
  logic signed [VW-1:0] val_mem [TABLE_DEPTH];
  logic        [CW-1:0] count;
  logic        [CW-1:0] count_next;
  logic signed [KW-1:0] first_key;
  logic signed [KW-1:0] last_key;

  // scan and arithmetic
  logic        [AW-1:0]              scan_idx;
  logic signed [KW-1:0]              rkey;
  logic signed [VW-1:0]              rval;
  logic signed [KW-1:0]              pkey;
  logic signed [VW-1:0]              pval;
  logic signed [KW:0]                dx;
  logic signed [VW:0]                df;
  logic signed [KW:0]                dn;
  logic signed [KW+VW+1:0]           prod;
  logic        [KW+VW+1:0]           prod_neg;
  logic        [tli_pkg::DEN_W-1:0]  den_q;
  logic        [tli_pkg::NUM_W-1:0]  mag;
  logic        [tli_pkg::NUM_W-1:0]  quo;
  logic        [VW-1:0]              qs;
  logic                              div_busy;
  logic signed [VW-1:0]              res_q;

  logic [tli_pkg::STATUS_W-1:0] status_eval;
  logic                         append_ok;
  logic                         query_ok;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_q <= in_req_type;
      x_q   <= in_angle;
      v_q   <= in_coefficient;
    end
  end

  // status of the latched request against the table
  always_comb begin
    status_eval = tli_pkg::ST_OK;
    unique case (req_q)
      tli_pkg::REQ_APPEND: begin
        if (count >= CW'(TABLE_DEPTH)) begin
          status_eval = tli_pkg::ST_FULL;
        end else if (count != '0 && x_q <= last_key) begin
          status_eval = tli_pkg::ST_ORDER;
        end
      end
      tli_pkg::REQ_QUERY: begin
        if (count == '0) begin
          status_eval = tli_pkg::ST_EMPTY;
        end else if (x_q < first_key || x_q > last_key) begin
          status_eval = tli_pkg::ST_SPAN;
        end
      end
      default: begin
        status_eval = tli_pkg::ST_OK;
      end
    endcase
  end

  assign append_ok = (req_q == tli_pkg::REQ_APPEND) && (status_eval == tli_pkg::ST_OK);
  assign query_ok  = (req_q == tli_pkg::REQ_QUERY) && (status_eval == tli_pkg::ST_OK);

  // count after this beat
  always_comb begin
    count_next = count;
    if (req_q == tli_pkg::REQ_CLEAR) begin
      count_next = '0;
    end else if (append_ok) begin
      count_next = count + 1'b1;
    end
  end

  // table control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && append_ok) begin
      last_key <= x_q;
      if (count == '0) begin
        first_key <= x_q;
      end
    end
  end

  // point memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.commit && append_ok) begin
      key_mem[count[AW-1:0]] <= x_q;
      val_mem[count[AW-1:0]] <= v_q;
    end
    rkey <= key_mem[scan_idx];
    rval <= val_mem[scan_idx];
  end

  // scan pointer and previous point
  always_ff @(posedge clk) begin
    if (cmd.scan_first) begin
      scan_idx <= '0;
    end else if (cmd.scan_next) begin
      scan_idx <= scan_idx + 1'b1;
      pkey     <= rkey;
      pval     <= rval;
    end
  end

  // interpolation terms
  assign dx = {x_q[KW-1], x_q} - {pkey[KW-1], pkey};
  assign df = {rval[VW-1], rval} - {pval[VW-1], pval};
  assign dn = {rkey[KW-1], rkey} - {pkey[KW-1], pkey};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod  <= dx * df;
      den_q <= dn[tli_pkg::DEN_W-1:0];
    end
  end

  // magnitude for the divider, sign applied after
  assign prod_neg = -prod;
  assign mag      = prod[KW+VW+1] ? prod_neg[tli_pkg::NUM_W-1:0] : prod[tli_pkg::NUM_W-1:0];

  tli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  (den_q),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign qs = prod[KW+VW+1] ? (VW'(0) - quo[VW-1:0]) : quo[VW-1:0];

  // query result
  always_ff @(posedge clk) begin
    if (cmd.take_exact) begin
      res_q <= rval;
    end else if (cmd.take_quot) begin
      res_q <= pval + $signed(qs);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_coef   <= query_ok ? res_q : '0;
      out_status <= status_eval;
      out_points <= tli_pkg::POINTS_W'(count_next);
    end
  end

  // status to the controller
  assign stat.need_scan = query_ok;
  assign stat.key_eq    = (rkey == x_q);
  assign stat.key_gt    = (rkey > x_q);
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = !out_valid || out_ready;

  // checks
  a_scan_in_table: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_next |-> (CW'(scan_idx) + 1'b1 < count))
    else $error("scan stepped past the stored points");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("result loaded over an untaken beat");

  a_quot_done: assert property (@(posedge clk) disable iff (rst)
    cmd.take_quot |-> !div_busy)
    else $error("quotient taken while divider busy");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && append_ok) |=> (count == $past(count) + 1'b1))
    else $error("accepted append did not grow the table");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("point count above table depth");

endmodule

// ===== design/table_linear_interpolator.sv =====
// Piecewise linear lookup table with one request beat in and one response beat out per item.
// Requests clear the table, append an (angle, coefficient) point in strictly rising angle
// order, or query an angle; a query returns the stored coefficient on an exact hit or the
// straight-line value between the neighbouring points, quotient truncated toward zero.
// One item is worked at a time. Clear, append, unused codes and flagged queries (empty table
// or out of span) go from accept to the result beat with no scan. A query scans the table from
// entry 0 and stops at an exact hit or at the first larger angle, where it multiplies and then
// divides to interpolate. The scan reads the point memory through its single registered port,
// and the division runs bit-serially at one quotient bit per cycle over 33 bits. The input is
// taken again in the cycle after the result is loaded into the output register, even while
// that beat is still waiting.
// The table needs no clearing pass: only entries below the point count are ever used.
module table_linear_interpolator #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  tli_req_if.sink  req,
  tli_rsp_if.source rsp
);

  tli_pkg::tli_cmd_t  cmd;
  tli_pkg::tli_stat_t stat;

  // sequencer
  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table, arithmetic and output register
  tli_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (req.req_type),
    .in_angle       (req.angle),
    .in_coefficient (req.coefficient),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_coef       (rsp.result_coef),
    .out_status     (rsp.status),
    .out_points     (rsp.points_stored)
  );

endmodule
